[rtl/xurg_pkg.sv]
// ----------------------------------------------------------------------------
// xurg_pkg: shared definitions of the xoshiro256** generator
// Holds the mixing constants, the action codes and the common widths.
// ----------------------------------------------------------------------------
package xurg_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned BoundW = 31;
  localparam int unsigned ActW   = 2;

  localparam logic [WordW-1:0] GOLDEN_GAMMA    = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MIX_MUL_A       = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MIX_MUL_B       = 64'h94d049bb133111eb;
  localparam logic [WordW-1:0] SEED_ZERO_SUBST = 64'h6a09e667f3bcc909;

  localparam logic [ActW-1:0] ACT_RAW  = 2'd0;
  localparam logic [ActW-1:0] ACT_UNI  = 2'd1;
  localparam logic [ActW-1:0] ACT_SEED = 2'd2;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [BoundW-1:0] bound_t;
  typedef logic [ActW-1:0]   act_t;

endpackage

[rtl/xurg_ifs.sv]
// ----------------------------------------------------------------------------
// xurg channel interfaces
// Valid/ready channels for request words, result words and seed writes.
// ----------------------------------------------------------------------------
interface xurg_in_if import xurg_pkg::*; ();
  logic   valid;
  logic   ready;
  act_t   action;
  bound_t bound;
  modport source (output valid, output action, output bound, input ready);
  modport sink   (input valid, input action, input bound, output ready);
endinterface

interface xurg_out_if import xurg_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface xurg_cfg_if import xurg_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t seed_value;
  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

[rtl/xoshiro_uniform_random_generator_core.sv]
// ----------------------------------------------------------------------------
// xoshiro_uniform_random_generator_core: xoshiro256** with splitmix64 seeding
// Raw 64-bit draws, unbiased uniform draws below a bound, and reseeding.
// ----------------------------------------------------------------------------
// The block handles one request word at a time and answers each with exactly
// one result word; in_ch.ready is high only while it is idle. A reseed runs
// four splitmix64 steps, each with two 64-bit multiplies on a shared 32x32
// multiplier (three partial products per multiply). A uniform draw first
// finds the rejection threshold on the bit-serial remainder unit, then makes
// raw draws, repeated while a draw falls below the threshold, and then takes
// the final modulo on the same unit. A bound of zero and the unused action
// code answer zero without a draw. After reset the block first expands seed
// one into the state, which keeps in_ch.ready low until the expansion ends.
// Seed writes on cfg_ch are always accepted and take effect on the next
// reseed; a result word waits in the output register until out_ch.ready
// takes it.
// ----------------------------------------------------------------------------
module xoshiro_uniform_random_generator_core import xurg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  xurg_in_if.sink    in_ch,
  xurg_out_if.source out_ch,
  xurg_cfg_if.sink   cfg_ch
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MIX_A  = 4'd1;
  localparam logic [3:0] S_MIX_WA = 4'd2;
  localparam logic [3:0] S_MIX_WB = 4'd3;
  localparam logic [3:0] S_THR    = 4'd4;
  localparam logic [3:0] S_RAW1   = 4'd5;
  localparam logic [3:0] S_RAW2   = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_MOD    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // Control state.
  logic [3:0] state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       ann_r, ann_nxt;
  logic       uni_r, uni_nxt;
  word_t      seed_r, seed_nxt;
  word_t      acc_r, acc_nxt;

  // Datapath.
  word_t  s_r [4];
  word_t  s_nxt [4];
  word_t  m5_r, m5_nxt;
  word_t  res_r, res_nxt;
  word_t  value_r, value_nxt;
  bound_t thr_r, thr_nxt;
  bound_t bound_r, bound_nxt;

  // Shared units.
  logic   mul_start;
  word_t  mul_a;
  word_t  mul_b;
  logic   mul_done;
  word_t  mul_p;
  logic   div_start;
  word_t  div_num;
  bound_t div_den;
  logic   div_done;
  bound_t div_rem;

  word_t  acc_sum;
  word_t  rot7;
  word_t  t17;
  word_t  n0, n1, n2, n3;

  xurg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  xurg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .rem      (div_rem)
  );

  // The xoshiro256** state update, applied in one step.
  always_comb begin
    acc_sum = acc_r + GOLDEN_GAMMA;
    rot7    = {m5_r[WordW-8:0], m5_r[WordW-1:WordW-7]};
    t17     = {s_r[1][WordW-18:0], 17'd0};
    n2      = s_r[2] ^ s_r[0];
    n3      = s_r[3] ^ s_r[1];
    n1      = s_r[1] ^ n2;
    n0      = s_r[0] ^ n3;
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ann_nxt   = ann_r;
    uni_nxt   = uni_r;
    seed_nxt  = seed_r;
    acc_nxt   = acc_r;
    m5_nxt    = m5_r;
    res_nxt   = res_r;
    value_nxt = value_r;
    thr_nxt   = thr_r;
    bound_nxt = bound_r;
    for (int i = 0; i < 4; i++) begin
      s_nxt[i] = s_r[i];
    end
    mul_start = 1'b0;
    mul_a     = acc_sum ^ (acc_sum >> 30);
    mul_b     = MIX_MUL_A;
    div_start = 1'b0;
    div_num   = res_r;
    div_den   = bound_r;

    if (cfg_ch.valid) begin
      seed_nxt = cfg_ch.seed_value;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          bound_nxt = in_ch.bound;
          value_nxt = '0;
          case (in_ch.action)
            ACT_RAW: begin
              uni_nxt   = 1'b0;
              state_nxt = S_RAW1;
            end
            ACT_UNI: begin
              uni_nxt = 1'b1;
              if (in_ch.bound == '0) begin
                state_nxt = S_OUT;
              end else begin
                // Threshold is (2^64 - bound) mod bound.
                div_start = 1'b1;
                div_num   = word_t'(0) - word_t'(in_ch.bound);
                div_den   = in_ch.bound;
                state_nxt = S_THR;
              end
            end
            ACT_SEED: begin
              ann_nxt   = 1'b1;
              k_nxt     = 2'd0;
              acc_nxt   = (seed_r == '0) ? SEED_ZERO_SUBST : seed_r;
              state_nxt = S_MIX_A;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_MIX_A: begin
        acc_nxt   = acc_sum;
        mul_start = 1'b1;
        state_nxt = S_MIX_WA;
      end
      S_MIX_WA: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_p ^ (mul_p >> 27);
          mul_b     = MIX_MUL_B;
          state_nxt = S_MIX_WB;
        end
      end
      S_MIX_WB: begin
        if (mul_done) begin
          s_nxt[k_r] = mul_p ^ (mul_p >> 31);
          k_nxt      = k_r + 2'd1;
          if (k_r == 2'd3) begin
            // The expansion after reset answers nothing; a reseed answers zero.
            state_nxt = ann_r ? S_OUT : S_IDLE;
            ann_nxt   = 1'b0;
          end else begin
            state_nxt = S_MIX_A;
          end
        end
      end
      S_THR: begin
        if (div_done) begin
          thr_nxt   = div_rem;
          state_nxt = S_RAW1;
        end
      end
      S_RAW1: begin
        m5_nxt    = s_r[1] + {s_r[1][WordW-3:0], 2'b00};
        state_nxt = S_RAW2;
      end
      S_RAW2: begin
        res_nxt   = rot7 + {rot7[WordW-4:0], 3'b000};
        s_nxt[0]  = n0;
        s_nxt[1]  = n1;
        s_nxt[2]  = n2 ^ t17;
        s_nxt[3]  = {n3[WordW-46:0], n3[WordW-1:WordW-45]};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!uni_r) begin
          value_nxt = res_r;
          state_nxt = S_OUT;
        end else if (res_r >= word_t'(thr_r)) begin
          div_start = 1'b1;
          state_nxt = S_MOD;
        end else begin
          // Rejected draw: the state has advanced, draw again.
          state_nxt = S_RAW1;
        end
      end
      S_MOD: begin
        if (div_done) begin
          value_nxt = word_t'(div_rem);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Reset starts the expansion of seed one into the state.
      state_r <= S_MIX_A;
      k_r     <= 2'd0;
      ann_r   <= 1'b0;
      uni_r   <= 1'b0;
      seed_r  <= word_t'(1);
      acc_r   <= word_t'(1);
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ann_r   <= ann_nxt;
      uni_r   <= uni_nxt;
      seed_r  <= seed_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s_r[i] <= s_nxt[i];
    end
    m5_r    <= m5_nxt;
    res_r   <= res_nxt;
    value_r <= value_nxt;
    thr_r   <= thr_nxt;
    bound_r <= bound_nxt;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.value = value_r;
  assign cfg_ch.ready = 1'b1;

endmodule

[rtl/xurg_mul.sv]
// ----------------------------------------------------------------------------
// xurg_mul: iterative 64x64 multiplier, low half of the product
// Uses one 32x32 multiplier for the three partial products and accumulates them.
// ----------------------------------------------------------------------------
module xurg_mul import xurg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t op_a,
  input  word_t op_b,
  output logic  done,
  output word_t prod
);

  word_t             a_r;
  word_t             b_r;
  word_t             acc_r;
  logic [1:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [HalfW-1:0]  x;
  logic [HalfW-1:0]  y;
  word_t             pp;

  // Only the three partial products that reach the low 64 bits are formed.
  always_comb begin
    case (cnt_r)
      2'd0:    begin x = a_r[HalfW-1:0];     y = b_r[HalfW-1:0];     end
      2'd1:    begin x = a_r[HalfW-1:0];     y = b_r[WordW-1:HalfW]; end
      default: begin x = a_r[WordW-1:HalfW]; y = b_r[HalfW-1:0];     end
    endcase
    pp = word_t'(x) * word_t'(y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
    end else if (busy_r) begin
      if (cnt_r == 2'd0) begin
        acc_r <= pp;
      end else begin
        acc_r <= acc_r + {pp[HalfW-1:0], {HalfW{1'b0}}};
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/xurg_div.sv]
// ----------------------------------------------------------------------------
// xurg_div: bit-serial remainder unit
// Restoring division of a 64-bit word by a 31-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module xurg_div import xurg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  word_t  dividend,
  input  bound_t divisor,
  output logic   done,
  output bound_t rem
);

  word_t             num_r;
  bound_t            den_r;
  bound_t            rem_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [BoundW:0]   trial;
  logic [BoundW:0]   diff;
  logic              ge;

  // The partial remainder stays below the divisor, so 31 bits hold it.
  always_comb begin
    trial = {rem_r, num_r[WordW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[WordW-2:0], 1'b0};
      rem_r <= ge ? diff[BoundW-1:0] : trial[BoundW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
